[rtl/core/wrt_pkg.sv]
// package: types, constants and codes shared by the rule table menu state machine
package wrt_pkg;

  localparam int RuleDepthDefault = 64;
  localparam int StateLimitDefault = 128;
  localparam logic [7:0] ANY_OR_KEEP = 8'hFF;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_EVENT = 3'd1;
  localparam logic [2:0] ACT_SET_POS = 3'd2;
  localparam logic [2:0] ACT_WR_VISIT = 3'd3;
  localparam logic [2:0] ACT_RD_VISIT = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_MATCH = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_BAD_ID = 3'd3;
  localparam logic [2:0] ST_DUP = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  match_state;
    logic [7:0]  match_page;
    logic [7:0]  match_button;
    logic [7:0]  event_code;
    logic [7:0]  next_state;
    logic [7:0]  next_page;
    logic [7:0]  next_button;
    logic [7:0]  op_first;
    logic [7:0]  op_second;
    logic [7:0]  op_third;
    logic [31:0] word_value;
  } wrt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] redraw_mask;
    logic [7:0]  cur_state;
    logic [7:0]  cur_page;
    logic [7:0]  cur_button;
    logic [7:0]  cur_substate;
    logic [7:0]  cur_op_first;
    logic [7:0]  cur_op_second;
    logic [7:0]  cur_op_third;
    logic [7:0]  prior_state;
    logic [31:0] visited_word;
  } wrt_out_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_CHECK,
    FSM_WRITE,
    FSM_DONE
  } wrt_fsm_t;

  function automatic logic [15:0] button_bit(input logic [7:0] b);
    logic [15:0] r;
    r = '0;
    if (b < 8'd16) begin
      r[b[3:0]] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic field_hits(input logic [7:0] r, input logic [7:0] v);
    return (r == ANY_OR_KEEP) || (r == v);
  endfunction

endpackage

[rtl/core/wrt_ram.sv]
// generic single port ram with registered read
module wrt_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/core/wildcard_rule_table_menu_fsm.sv]
// top level: rule table menu state machine with a sequential rule scan
// an add scans the stored rules (one ram read per rule) for a duplicate when validation is on,
// then writes; an event scans up to the first matching rule or the end of the table; other
// actions go straight to the result; one transaction at a time: in_stall holds until the result leaves
// reset: synchronous; clears rule count, position, ops, visited map and sets validation on
module wildcard_rule_table_menu_fsm #(
  parameter int RULE_DEPTH = wrt_pkg::RuleDepthDefault,
  parameter int STATE_LIMIT = wrt_pkg::StateLimitDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  wrt_pkg::wrt_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output wrt_pkg::wrt_out_t out_data
);
  import wrt_pkg::*;

  localparam int AW = $clog2(RULE_DEPTH);
  localparam int CW = $clog2(RULE_DEPTH + 1);

  wrt_fsm_t state, state_next;
  wrt_in_t req;
  logic validation_on;
  logic [CW-1:0] rule_count;
  logic [CW-1:0] idx, idx_next;
  logic [31:0] position_now, position_before;
  logic [23:0] ops_now;
  logic [31:0] visited_map [4];
  logic [2:0] status;
  logic [15:0] mask;
  logic [31:0] word;
  logic found;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] match_rd;
  logic [47:0] target_rd;
  logic [31:0] key;
  logic rd_valid;
  logic bad_id;
  logic hit;

  assign key = {req.event_code, req.match_button, req.match_page, req.match_state};
  assign bad_id = validation_on &&
    ((req.match_state != ANY_OR_KEEP && req.match_state >= 8'(STATE_LIMIT)) ||
     (req.next_state != ANY_OR_KEEP && req.next_state >= 8'(STATE_LIMIT)));
  assign hit = (req.action == ACT_ADD) ? (match_rd == key) :
    (field_hits(match_rd[7:0], position_now[7:0]) &&
     field_hits(match_rd[15:8], position_now[15:8]) &&
     field_hits(match_rd[23:16], position_now[23:16]) &&
     field_hits(match_rd[31:24], req.event_code));

  assign ram_addr = (state == FSM_WRITE) ? rule_count[AW-1:0] : idx[AW-1:0];

  wrt_ram #(.Width(32), .Depth(RULE_DEPTH)) u_match_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(key), .rdata(match_rd));
  wrt_ram #(.Width(48), .Depth(RULE_DEPTH)) u_target_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({req.op_third, req.op_second, req.op_first, req.next_button,
            req.next_page, req.next_state}),
    .rdata(target_rd));

  assign in_stall = (state != FSM_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    ram_we = 1'b0;
    case (state)
      FSM_IDLE: begin
        idx_next = '0;
        if (in_valid) begin
          if (in_data.action == ACT_ADD || in_data.action == ACT_EVENT) begin
            state_next = FSM_SCAN;
          end else begin
            state_next = FSM_DONE;
          end
        end
      end
      FSM_SCAN: begin
        // one rule read issued per cycle, result checked next cycle
        if (rd_valid && hit && (req.action == ACT_EVENT || validation_on)) begin
          state_next = FSM_DONE;
        end else if (idx >= rule_count) begin
          state_next = (req.action == ACT_ADD) ? FSM_WRITE : FSM_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      FSM_WRITE: begin
        ram_we = (rule_count < CW'(RULE_DEPTH)) && !bad_id;
        state_next = FSM_DONE;
      end
      FSM_DONE: begin
        if (!out_stall) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      validation_on <= 1'b1;
      rule_count <= '0;
      position_now <= '0;
      position_before <= '0;
      ops_now <= '0;
      for (int i = 0; i < 4; i++) begin
        visited_map[i] <= '0;
      end
      rd_valid <= 1'b0;
      found <= 1'b0;
      idx <= '0;
    end else begin
      if (cfg_we) begin
        validation_on <= cfg_wdata;
      end
      idx <= idx_next;
      rd_valid <= (state == FSM_SCAN) && (idx < rule_count);
      if (state == FSM_IDLE && in_valid) begin
        req <= in_data;
        status <= ST_OK;
        mask <= '0;
        word <= '0;
        found <= 1'b0;
        case (in_data.action)
          ACT_SET_POS: begin
            position_before <= position_now;
            position_now <= {in_data.word_value[7:0], in_data.next_button,
                             in_data.next_page, in_data.next_state};
          end
          ACT_WR_VISIT: begin
            if (in_data.match_state < 8'd4) begin
              visited_map[in_data.match_state[1:0]] <= in_data.word_value;
            end
          end
          ACT_RD_VISIT: begin
            word <= (in_data.match_state < 8'd4) ? visited_map[in_data.match_state[1:0]] : '0;
          end
          default: ;
        endcase
      end
      if (state == FSM_SCAN) begin
        if (rd_valid && hit && req.action == ACT_EVENT) begin
          logic [7:0] ns, np, nb;
          ns = (target_rd[7:0] == ANY_OR_KEEP) ? position_now[7:0] : target_rd[7:0];
          np = (target_rd[15:8] == ANY_OR_KEEP) ? position_now[15:8] : target_rd[15:8];
          nb = (target_rd[23:16] == ANY_OR_KEEP) ? position_now[23:16] : target_rd[23:16];
          found <= 1'b1;
          ops_now <= target_rd[47:24];
          if (!position_now[7]) begin
            visited_map[position_now[6:5]][position_now[4:0]] <= 1'b1;
          end
          position_before <= position_now;
          position_now <= {position_now[31:24], nb, np, ns};
          if (np != position_now[15:8]) begin
            mask <= 16'hFFFF;
          end else if (nb != position_now[23:16]) begin
            mask <= button_bit(position_now[23:16]) | button_bit(nb);
          end
        end else if (rd_valid && hit && validation_on && req.action == ACT_ADD) begin
          status <= (rule_count >= CW'(RULE_DEPTH)) ? ST_FULL :
                    bad_id ? ST_BAD_ID : ST_DUP;
        end else if (idx >= rule_count && req.action == ACT_EVENT) begin
          status <= ST_NO_MATCH;
        end
      end
      if (state == FSM_WRITE) begin
        if (rule_count >= CW'(RULE_DEPTH)) begin
          status <= ST_FULL;
        end else if (bad_id) begin
          status <= ST_BAD_ID;
        end else begin
          rule_count <= rule_count + 1'b1;
        end
      end
    end
  end

  assign out_valid = (state == FSM_DONE);
  always_comb begin
    out_data.status = status;
    out_data.redraw_mask = mask;
    out_data.cur_state = position_now[7:0];
    out_data.cur_page = position_now[15:8];
    out_data.cur_button = position_now[23:16];
    out_data.cur_substate = position_now[31:24];
    out_data.cur_op_first = ops_now[7:0];
    out_data.cur_op_second = ops_now[15:8];
    out_data.cur_op_third = ops_now[23:16];
    out_data.prior_state = position_before[7:0];
    out_data.visited_word = word;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rule_count <= CW'(RULE_DEPTH)) else $error("rule count overflow");
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> rule_count < CW'(RULE_DEPTH)) else $error("write into full table");
  a_found_event: assert property (@(posedge clk) disable iff (rst)
    found |-> req.action == ACT_EVENT) else $error("match flag on non event");
`endif
endmodule
